// ===== hdl/cfl_pkg.sv =====
// shared types and constants for the circular free list
`default_nettype none
package cfl_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 6;
  // widest index the pool can need
  localparam int unsigned EXT_W = 12;
  localparam int unsigned LIM_W = 13;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic init_step;
    logic accept;
    logic eval;
    logic link;
    logic load_out;
  } cfl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic need_link;
    logic out_free;
  } cfl_sts_t;

endpackage
`default_nettype wire

// ===== hdl/cfl_ctrl.sv =====
// control state machine for the circular free list
`default_nettype none
module cfl_ctrl
  import cfl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cfl_sts_t sts_i,
  output cfl_cmd_t      cmd_o
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_LINK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_link ? ST_LINK : ST_DONE;
      end
      ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cfl_dp.sv =====
// link tables, head pointer and result register of the circular free list
`default_nettype none
module cfl_dp
  import cfl_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfl_cmd_t         cmd_i,
  output cfl_sts_t              sts_o,
  input  wire logic [OP_W-1:0]  kind_i,
  input  wire logic [IDX_W-1:0] entry_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [IDX_W-1:0]      popped_entry_o,
  output logic                  success_o,
  output logic [IDX_W-1:0]      head_entry_o,
  output logic                  list_empty_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [LIM_W-1:0] POOL_LIM = LIM_W'(ENTRIES);

  logic [IW-1:0] next_tab [ENTRIES];
  logic [IW-1:0] prev_tab [ENTRIES];
  logic          listed_tab [ENTRIES];

  logic [IW-1:0] init_cnt_q;
  logic [IW-1:0] head_q;
  logic          empty_q;

  logic [OP_W-1:0] kind_q;
  logic [IW-1:0]   e_q;
  logic            pool_q;
  logic [IW-1:0]   tgt_q;
  logic [IW-1:0]   tail_q;
  logic            ok_q;
  logic [IW-1:0]   popped_q;

  logic [IW-1:0] next_rd_q;
  logic [IW-1:0] prev_rd_q;
  logic          listed_rd_q;

  logic          out_valid_q;
  logic [IDX_W-1:0] popped_out_q;
  logic          success_q;
  logic [IDX_W-1:0] head_out_q;
  logic          empty_out_q;

  logic [EXT_W-1:0] in_ext;
  logic [IW-1:0]    in_e;
  logic             in_pool;

  logic ins_ok;
  logic pop_ok;
  logic rem_ok;
  logic take;
  logic single;

  logic          next_we;
  logic [IW-1:0] next_wa;
  logic [IW-1:0] next_wd;
  logic          prev_we;
  logic [IW-1:0] prev_wa;
  logic [IW-1:0] prev_wd;
  logic          listed_we;
  logic [IW-1:0] listed_wa;
  logic          listed_wd;

  logic [EXT_W-1:0] head_ext;
  logic [EXT_W-1:0] popped_ext;

  assign in_ext  = {{(EXT_W-IDX_W){1'b0}}, entry_index_i};
  assign in_e    = in_ext[IW-1:0];
  assign in_pool = ({{(LIM_W-IDX_W){1'b0}}, entry_index_i} < POOL_LIM);

  assign ins_ok = (kind_q == OP_INSERT) && pool_q && !listed_rd_q;
  assign pop_ok = (kind_q == OP_POP) && !empty_q;
  assign rem_ok = (kind_q == OP_REMOVE) && pool_q && listed_rd_q && !empty_q;
  assign take   = pop_ok || rem_ok;
  assign single = (next_rd_q == tgt_q);

  assign sts_o.init_last = (init_cnt_q == LAST);
  assign sts_o.need_link = ins_ok && !empty_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // table write ports
  always_comb begin
    next_we   = 1'b0;
    next_wa   = '0;
    next_wd   = '0;
    prev_we   = 1'b0;
    prev_wa   = '0;
    prev_wd   = '0;
    listed_we = 1'b0;
    listed_wa = '0;
    listed_wd = 1'b0;
    if (cmd_i.init_step) begin
      next_we   = 1'b1;
      next_wa   = init_cnt_q;
      next_wd   = (init_cnt_q == LAST) ? '0 : init_cnt_q + 1'b1;
      prev_we   = 1'b1;
      prev_wa   = init_cnt_q;
      prev_wd   = (init_cnt_q == '0) ? LAST : init_cnt_q - 1'b1;
      listed_we = 1'b1;
      listed_wa = init_cnt_q;
      listed_wd = 1'b1;
    end else if (cmd_i.eval) begin
      if (ins_ok) begin
        next_we   = 1'b1;
        next_wa   = e_q;
        next_wd   = empty_q ? e_q : head_q;
        prev_we   = 1'b1;
        prev_wa   = e_q;
        prev_wd   = empty_q ? e_q : prev_rd_q;
        listed_we = 1'b1;
        listed_wa = e_q;
        listed_wd = 1'b1;
      end else if (take) begin
        listed_we = 1'b1;
        listed_wa = tgt_q;
        listed_wd = 1'b0;
        if (!single) begin
          prev_we = 1'b1;
          prev_wa = next_rd_q;
          prev_wd = prev_rd_q;
          next_we = 1'b1;
          next_wa = prev_rd_q;
          next_wd = next_rd_q;
        end
      end
    end else if (cmd_i.link) begin
      next_we = 1'b1;
      next_wa = tail_q;
      next_wd = e_q;
      prev_we = 1'b1;
      prev_wa = head_q;
      prev_wd = e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_tab[next_wa] <= next_wd;
    end
    if (cmd_i.accept) begin
      next_rd_q <= next_tab[(kind_i == OP_REMOVE) ? in_e : head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_tab[prev_wa] <= prev_wd;
    end
    if (cmd_i.accept) begin
      prev_rd_q <= prev_tab[(kind_i == OP_REMOVE) ? in_e : head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (listed_we) begin
      listed_tab[listed_wa] <= listed_wd;
    end
    if (cmd_i.accept) begin
      listed_rd_q <= listed_tab[in_e];
    end
  end

  // item and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      e_q    <= in_e;
      pool_q <= in_pool;
      tgt_q  <= (kind_i == OP_REMOVE) ? in_e : head_q;
    end
    if (cmd_i.eval) begin
      tail_q   <= prev_rd_q;
      ok_q     <= ins_ok || take;
      popped_q <= pop_ok ? head_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
      head_q     <= '0;
      empty_q    <= 1'b0;
    end else begin
      if (cmd_i.init_step && (init_cnt_q != LAST)) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (cmd_i.eval) begin
        if (ins_ok && empty_q) begin
          head_q  <= e_q;
          empty_q <= 1'b0;
        end else if (take && single) begin
          head_q  <= '0;
          empty_q <= 1'b1;
        end else if (take && (head_q == tgt_q)) begin
          head_q <= next_rd_q;
        end
      end
    end
  end

  // result register
  assign head_ext   = EXT_W'(head_q);
  assign popped_ext = EXT_W'(popped_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      popped_out_q <= popped_ext[IDX_W-1:0];
      success_q    <= ok_q;
      head_out_q   <= empty_q ? '0 : head_ext[IDX_W-1:0];
      empty_out_q  <= empty_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_entry_o = popped_out_q;
  assign success_o      = success_q;
  assign head_entry_o   = head_out_q;
  assign list_empty_o   = empty_out_q;

endmodule
`default_nettype wire

// ===== hdl/circular_free_list.sv =====
// circular doubly linked free list over a pool of ENTRIES entries
// an item steps through accept, eval and done, with a link step between eval
// and done for an insert into a non-empty list (two writes each to the single-port
// next and prev tables); done loads the result once the output register is free,
// and only then is a new item accepted; after reset a clearing pass builds the list
// 0..ENTRIES-1, and no item is accepted until it ends
`default_nettype none
module circular_free_list
  import cfl_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [OP_W-1:0]  kind_i,
  input  wire logic [IDX_W-1:0] entry_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [IDX_W-1:0]      popped_entry_o,
  output logic                  success_o,
  output logic [IDX_W-1:0]      head_entry_o,
  output logic                  list_empty_o
);

  cfl_cmd_t cmd;
  cfl_sts_t sts;

  cfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_entry_o (popped_entry_o),
    .success_o      (success_o),
    .head_entry_o   (head_entry_o),
    .list_empty_o   (list_empty_o)
  );

endmodule
`default_nettype wire

// ===== hdl/cfl_checker.sv =====
// port-level checks for the circular free list
`default_nettype none
module cfl_checker
  import cfl_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [IDX_W-1:0] popped_entry_o,
  input wire logic             success_o,
  input wire logic [IDX_W-1:0] head_entry_o,
  input wire logic             list_empty_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(popped_entry_o) && $stable(success_o)
      && $stable(head_entry_o) && $stable(list_empty_o))
    else $error("stalled result changed");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_empty_o |-> head_entry_o == '0)
    else $error("empty list reports a head");

  a_pop_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (popped_entry_o != '0) |-> success_o)
    else $error("popped entry on a failed item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

endmodule

bind circular_free_list cfl_checker u_cfl_checker (.*);
`default_nettype wire
